FILE: src/handle_slot_registry_unit_defines.svh
// ----------------------------------------------------------------------------
// handle_slot_registry_unit_defines
// Assertion macros used by the handle slot registry RTL.
// ----------------------------------------------------------------------------
`ifndef HANDLE_SLOT_REGISTRY_UNIT_DEFINES_SVH
`define HANDLE_SLOT_REGISTRY_UNIT_DEFINES_SVH

// same-cycle implication
`define HSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hsr assertion failed");

// next-cycle implication
`define HSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hsr assertion failed");

`endif

FILE: src/hsr_pkg.sv
// ----------------------------------------------------------------------------
// hsr_pkg
// Shared constants and types of the handle slot registry.
// ----------------------------------------------------------------------------
package hsr_pkg;

    localparam int SLOT_COUNT_DEF = 64;
    localparam int KEY_BITS_DEF   = 32;

    localparam int STATUS_BITS = 3;
    localparam int SLOT_BITS   = 6;
    localparam int INDEX_BITS  = 7;

    localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_DELETED   = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_IGNORED   = 3'd4;

    // request broadcast to every cell
    typedef struct packed {
        logic is_del;
        logic del_go;
    } t_cmd;

    // scan token flags handed from cell to cell
    typedef struct packed {
        logic valid;
        logic dup;
        logic found;
        logic del_empty;
    } t_flags;

endpackage

FILE: src/handle_slot_registry_unit.sv
// ----------------------------------------------------------------------------
// handle_slot_registry_unit
// Registry of SLOT_COUNT nonzero keys with duplicate check and lowest-free
// allocation, built as a chain of slot cells walked by a scan token.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a beat is taken at a rising edge with start high and busy
//   low. i_mode 0 registers i_key, i_mode 1 deletes slot i_slot_index.
//   Result channel: o_valid marks one cycle carrying o_status and o_slot; the
//   receiver must take it in that cycle, there is no back-pressure.
//   The token walks one cell per cycle: each slot cell registers it, and the
//   result is registered from the token leaving the last cell.
//   busy drops together with o_valid, so a new beat is taken at the edge ending
//   the result cycle; no command is taken before the last one has its result.
//   The store of a new key happens at the edge the result is registered, so
//   the next command already sees it.
//   Reset: synchronous, active low; clears every slot to empty, drops busy and
//   any scan in flight. Ready for a command once reset is released.
// ----------------------------------------------------------------------------
`include "handle_slot_registry_unit_defines.svh"

module handle_slot_registry_unit #(
    parameter int SLOT_COUNT = hsr_pkg::SLOT_COUNT_DEF,
    parameter int KEY_BITS   = hsr_pkg::KEY_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_mode,
    input  logic [KEY_BITS-1:0]             i_key,
    input  logic [hsr_pkg::INDEX_BITS-1:0]  i_slot_index,
    output logic                            o_valid,
    output logic [hsr_pkg::STATUS_BITS-1:0] o_status,
    output logic [hsr_pkg::SLOT_BITS-1:0]   o_slot
);

    localparam int IDX_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state                          r_state;
    logic                            r_busy;
    logic                            r_launch;
    logic                            r_mode;
    logic                            r_in_range;
    logic [KEY_BITS-1:0]             r_key;
    logic [IDX_BITS-1:0]             r_del_sel;
    logic                            r_valid;
    logic [hsr_pkg::STATUS_BITS-1:0] r_status;
    logic [hsr_pkg::SLOT_BITS-1:0]   r_slot;

    hsr_pkg::t_cmd                   cmd;
    hsr_pkg::t_flags                 w_flags [0:SLOT_COUNT];
    logic [IDX_BITS-1:0]             w_free  [0:SLOT_COUNT];
    logic [SLOT_COUNT:0]             w_tok_valid;
    hsr_pkg::t_flags                 fin_flags;
    logic                            fin;
    logic                            wr_en;
    logic [hsr_pkg::STATUS_BITS-1:0] n_status;
    logic [hsr_pkg::SLOT_BITS-1:0]   n_slot;

    assign cmd.is_del = r_mode;
    assign cmd.del_go = r_mode && r_in_range;

    always_comb begin
        w_flags[0]       = '0;
        w_flags[0].valid = r_launch;
        w_free[0]        = '0;
    end

    genvar g;
    generate
        for (g = 0; g < SLOT_COUNT; g++) begin : g_cell
            hsr_cell #(
                .KEY_BITS (KEY_BITS),
                .IDX_BITS (IDX_BITS),
                .CELL_IDX (g)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cmd      (cmd),
                .i_key      (r_key),
                .i_del_sel  (r_del_sel),
                .i_wr_en    (wr_en),
                .i_wr_sel   (w_free[SLOT_COUNT]),
                .i_flags    (w_flags[g]),
                .i_free_idx (w_free[g]),
                .o_flags    (w_flags[g+1]),
                .o_free_idx (w_free[g+1])
            );
        end
        for (g = 0; g <= SLOT_COUNT; g++) begin : g_tok
            assign w_tok_valid[g] = w_flags[g].valid;
        end
    endgenerate

    assign fin_flags = w_flags[SLOT_COUNT];
    assign fin       = fin_flags.valid;
    assign wr_en     = fin && !r_mode && !fin_flags.dup && fin_flags.found;

    always_comb begin
        n_status = hsr_pkg::ST_OK;
        n_slot   = '0;
        if (!r_mode) begin
            if (fin_flags.dup) begin
                n_status = hsr_pkg::ST_DUPLICATE;
            end else if (!fin_flags.found) begin
                n_status = hsr_pkg::ST_FULL;
            end else begin
                n_slot = hsr_pkg::SLOT_BITS'(w_free[SLOT_COUNT]);
            end
        end else if (!r_in_range) begin
            n_status = hsr_pkg::ST_IGNORED;
        end else if (fin_flags.del_empty) begin
            n_status = hsr_pkg::ST_DELETED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_launch <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_launch <= 1'b0;
            r_valid  <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_mode     <= i_mode;
                        r_key      <= i_key;
                        r_del_sel  <= IDX_BITS'(i_slot_index);
                        r_in_range <= (i_slot_index != '0)
                                      && (32'(i_slot_index) < SLOT_COUNT);
                        r_launch   <= 1'b1;
                        r_busy     <= 1'b1;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (fin) begin
                        r_valid  <= 1'b1;
                        r_status <= n_status;
                        r_slot   <= n_slot;
                        r_busy   <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = r_busy;
    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_slot   = r_slot;

    `HSR_ASSERT_IMP(a_single_token, i_clk, i_rst_n, 1'b1, $onehot0(w_tok_valid))
    `HSR_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `HSR_ASSERT_NEXT(a_finish_result, i_clk, i_rst_n, fin, o_valid && !busy)
    `HSR_ASSERT_IMP(a_slot_only_ok, i_clk, i_rst_n, o_valid && (o_slot != '0), o_status == hsr_pkg::ST_OK)

endmodule

FILE: src/hsr_cell.sv
// ----------------------------------------------------------------------------
// hsr_cell
// One registry slot: holds a key, folds its compare results into the passing
// scan token and hands the token to the next cell.
// ----------------------------------------------------------------------------
module hsr_cell #(
    parameter int KEY_BITS = hsr_pkg::KEY_BITS_DEF,
    parameter int IDX_BITS = 6,
    parameter int CELL_IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hsr_pkg::t_cmd       i_cmd,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [IDX_BITS-1:0] i_del_sel,
    input  logic                i_wr_en,
    input  logic [IDX_BITS-1:0] i_wr_sel,
    input  hsr_pkg::t_flags     i_flags,
    input  logic [IDX_BITS-1:0] i_free_idx,
    output hsr_pkg::t_flags     o_flags,
    output logic [IDX_BITS-1:0] o_free_idx
);

    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_IDX);

    logic [KEY_BITS-1:0] r_slot_key;
    logic [KEY_BITS-1:0] n_slot_key;
    hsr_pkg::t_flags     r_flags;
    hsr_pkg::t_flags     n_flags;
    logic [IDX_BITS-1:0] r_free_idx;
    logic [IDX_BITS-1:0] n_free_idx;

    logic empty;
    logic match;
    logic del_here;

    assign empty    = (r_slot_key == '0);
    assign match    = (r_slot_key == i_key);
    assign del_here = i_cmd.del_go && (i_del_sel == MY_IDX);

    always_comb begin
        n_flags       = i_flags;
        n_free_idx    = i_free_idx;
        n_flags.dup   = i_flags.dup | (i_flags.valid & ~i_cmd.is_del & match);
        n_flags.del_empty = i_flags.del_empty | (i_flags.valid & del_here & empty);
        if (i_flags.valid && !i_cmd.is_del && !i_flags.found && empty) begin
            n_flags.found = 1'b1;
            n_free_idx    = MY_IDX;
        end
        n_slot_key = r_slot_key;
        if (i_wr_en && (i_wr_sel == MY_IDX)) begin
            n_slot_key = i_key;
        end else if (i_flags.valid && del_here) begin
            n_slot_key = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_key <= '0;
            r_flags    <= '0;
        end else begin
            r_slot_key <= n_slot_key;
            r_flags    <= n_flags;
        end
        r_free_idx <= n_free_idx;
    end

    assign o_flags    = r_flags;
    assign o_free_idx = r_free_idx;

endmodule

FILE: dv/handle_slot_registry_unit_test.sv
// ----------------------------------------------------------------------------
// handle_slot_registry_unit_test
// Self-checking bench for the handle slot registry. Drives register and
// delete beats on the command port and predicts each status and slot from a
// local copy of the key table. Every strobed result is checked in order.
// Covers the empty, partly filled and full table, zero keys, slot zero and
// out-of-table indexes, with random idle gaps on the command side.
// ----------------------------------------------------------------------------
module handle_slot_registry_unit_test;

    localparam int SLOTS = hsr_pkg::SLOT_COUNT_DEF;
    localparam int KEY_W = hsr_pkg::KEY_BITS_DEF;
    localparam int IDX_W = hsr_pkg::INDEX_BITS;

    localparam logic MODE_REGISTER = 1'b0;
    localparam logic MODE_DELETE   = 1'b1;

    typedef struct packed {
        logic [hsr_pkg::STATUS_BITS-1:0] status;
        logic [hsr_pkg::SLOT_BITS-1:0]   slot;
    } t_registry_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    logic                            i_mode;
    logic [KEY_W-1:0]                i_key;
    logic [IDX_W-1:0]                i_slot_index;
    logic                            o_valid;
    logic [hsr_pkg::STATUS_BITS-1:0] o_status;
    logic [hsr_pkg::SLOT_BITS-1:0]   o_slot;

    logic [KEY_W-1:0]   slot_key_model [SLOTS];
    t_registry_result   pending_results [$];
    bit                 sender_idles = 1'b1;
    int                 beats_sent = 0;
    int                 results_seen = 0;
    int                 mismatch_count = 0;
    int                 status_count [8];

    handle_slot_registry_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_key        (i_key),
        .i_slot_index (i_slot_index),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_slot       (o_slot)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_registry_result apply_request(logic mode, logic [KEY_W-1:0] key,
                                                       logic [IDX_W-1:0] idx);
        t_registry_result res;
        int free_slot;
        res.status = hsr_pkg::ST_OK;
        res.slot   = '0;
        free_slot  = -1;
        if (mode == MODE_REGISTER) begin
            foreach (slot_key_model[i]) begin
                if (slot_key_model[i] == key) res.status = hsr_pkg::ST_DUPLICATE;
            end
            if (res.status == hsr_pkg::ST_OK) begin
                for (int i = SLOTS - 1; i >= 0; i--) begin
                    if (slot_key_model[i] == '0) free_slot = i;
                end
                if (free_slot < 0) begin
                    res.status = hsr_pkg::ST_FULL;
                end else begin
                    slot_key_model[free_slot] = key;
                    res.slot = free_slot[hsr_pkg::SLOT_BITS-1:0];
                end
            end
        end else if (idx == 0 || idx >= SLOTS) begin
            res.status = hsr_pkg::ST_IGNORED;
        end else if (slot_key_model[idx] == '0) begin
            res.status = hsr_pkg::ST_DELETED;
        end else begin
            slot_key_model[idx] = '0;
        end
        return res;
    endfunction

    // random slot with the given occupancy, or -1
    function automatic int find_slot(bit occupied);
        int base;
        int j;
        base = $urandom_range(SLOTS - 1);
        for (int n = 0; n < SLOTS; n++) begin
            j = (base + n) % SLOTS;
            if ((slot_key_model[j] != '0) == occupied) return j;
        end
        return -1;
    endfunction

    task automatic send_beat(input logic mode, input logic [KEY_W-1:0] key,
                             input logic [IDX_W-1:0] idx);
        if (sender_idles && $urandom_range(99) < 29) begin
            start <= 1'b0;
            repeat ($urandom_range(1) ? $urandom_range(1, 8) : $urandom_range(1, 90))
                @(posedge i_clk);
        end
        start        <= 1'b1;
        i_mode       <= mode;
        i_key        <= key;
        i_slot_index <= idx;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(apply_request(mode, key, idx));
        beats_sent++;
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    always @(posedge i_clk) begin
        t_registry_result exp_res;
        if (i_rst_n && o_valid) begin
            results_seen++;
            status_count[o_status]++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: status %0d slot %0d", o_status, o_slot);
            end else begin
                exp_res = pending_results.pop_front();
                if (o_status !== exp_res.status || o_slot !== exp_res.slot) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp status %0d slot %0d, got status %0d slot %0d",
                                 exp_res.status, exp_res.slot, o_status, o_slot);
                end
            end
        end
    end

    task automatic test_empty_registry();
        send_beat(MODE_DELETE, 32'h0000_0000, 7'd5);
        send_beat(MODE_DELETE, 32'hFFFF_FFFF, 7'd0);
        send_beat(MODE_DELETE, 32'h0000_0000, 7'd127);
        send_beat(MODE_DELETE, 32'h0000_0000, 7'd64);
        send_beat(MODE_REGISTER, 32'h0000_0000, 7'd127);
        send_beat(MODE_REGISTER, 32'hFFFF_FFFF, 7'd0);
        send_beat(MODE_REGISTER, 32'hFFFF_FFFF, 7'd3);
        send_beat(MODE_REGISTER, 32'h0000_0001, 7'd0);
        send_beat(MODE_DELETE, 32'h0000_0000, 7'd0);
        send_beat(MODE_DELETE, 32'h0000_0000, 7'd1);
        send_beat(MODE_DELETE, 32'h0000_0000, 7'd1);
        send_beat(MODE_REGISTER, 32'h8000_0000, 7'd63);
        send_beat(MODE_DELETE, 32'h0000_0000, 7'd63);
    endtask

    task automatic test_fill_to_full();
        while (find_slot(1'b0) >= 0)
            send_beat(MODE_REGISTER, $urandom, IDX_W'($urandom_range(127)));
        send_beat(MODE_REGISTER, 32'h0000_0000, 7'd0);
        send_beat(MODE_REGISTER, $urandom, 7'd0);
        send_beat(MODE_REGISTER, slot_key_model[17], 7'd17);
        send_beat(MODE_DELETE, $urandom, 7'd63);
        send_beat(MODE_REGISTER, 32'h5A5A_A5A5, 7'd0);
        send_beat(MODE_DELETE, 32'h0000_0000, 7'd0);
        send_beat(MODE_DELETE, 32'h0000_0000, 7'd64);
    endtask

    task automatic test_random_traffic();
        int               r;
        int               s;
        bit               fill_phase;
        logic             mode;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] idx;
        for (int blk = 0; blk < 8; blk++) begin
            fill_phase   = (blk % 2 == 0);
            sender_idles = (blk != 3);
            for (int n = 0; n < 215; n++) begin
                mode = MODE_REGISTER;
                key  = $urandom;
                idx  = IDX_W'($urandom_range(127));
                r    = $urandom_range(99);
                if (r >= (fill_phase ? 60 : 20)) begin
                    if (r < (fill_phase ? 70 : 28)) begin
                        s = find_slot(1'b1);
                        if (s >= 0) key = slot_key_model[s];
                    end else if (r < (fill_phase ? 73 : 32)) begin
                        key = '0;
                    end else begin
                        mode = MODE_DELETE;
                        if (r < (fill_phase ? 90 : 80)) begin
                            s = find_slot(1'b1);
                            if (s >= 0) idx = IDX_W'(s);
                        end else if (r < 95) begin
                            s = find_slot(1'b0);
                            if (s >= 0) idx = IDX_W'(s);
                        end
                    end
                end
                send_beat(mode, key, idx);
            end
            if (blk == 0) wait_drain();
        end
        sender_idles = 1'b1;
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_mode       <= MODE_REGISTER;
        i_key        <= '0;
        i_slot_index <= '0;
        foreach (slot_key_model[i]) slot_key_model[i] = '0;
        foreach (status_count[i]) status_count[i] = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_registry();
        test_fill_to_full();
        test_random_traffic();
        wait_drain();
        repeat (SLOTS + 10) @(posedge i_clk);
        $display("covered %0d command beats, %0d results checked, %0d mismatches",
                 beats_sent, results_seen, mismatch_count);
        $display("status mix: ok %0d, duplicate %0d, full %0d, already deleted %0d, ignored %0d",
                 status_count[hsr_pkg::ST_OK], status_count[hsr_pkg::ST_DUPLICATE],
                 status_count[hsr_pkg::ST_FULL], status_count[hsr_pkg::ST_DELETED],
                 status_count[hsr_pkg::ST_IGNORED]);
        if (mismatch_count == 0) begin
            $display("[handle_slot_registry_unit] OK");
        end else begin
            $display("[handle_slot_registry_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[handle_slot_registry_unit] ERROR");
        $finish;
    end

endmodule
